### hw/rtl/lru_tag_cache_lookup_assert.svh
// Assertion macros used by the checker file of the tag cache lookup block.
`ifndef LRU_TAG_CACHE_LOOKUP_ASSERT_SVH
`define LRU_TAG_CACHE_LOOKUP_ASSERT_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define LTC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ltc assertion failed");

// Antecedent in one cycle, consequent in the next.
`define LTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ltc assertion failed");

`endif

### hw/rtl/ltc_pkg.sv
// Types and constants of the tag cache lookup block.
package ltc_pkg;

  localparam int unsigned MaxEntries = 128;
  localparam int unsigned SlotW      = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned TagW       = 32;
  localparam int unsigned CfgW       = 8;

  localparam logic [CfgW-1:0] ActiveReset = CfgW'(64);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StPromote,
    StDone
  } ltc_state_e;

  // Write side of the entry store.
  typedef struct packed {
    logic             flush;
    logic             tag_we;
    logic [SlotW-1:0] tag_addr;
    logic [TagW-1:0]  tag_data;
    logic             rank_we;
    logic [SlotW-1:0] rank_addr;
    logic [SlotW-1:0] rank_data;
  } store_wr_t;

  // Registered read data of one entry.
  typedef struct packed {
    logic             valid;
    logic [TagW-1:0]  tag;
    logic [SlotW-1:0] rank;
  } store_rd_t;

endpackage

### hw/rtl/ltc_entry_store.sv
// Entry store: tag and rank memories with per-entry valid and rank-written bits.
module ltc_entry_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ltc_pkg::SlotW-1:0]      rd_addr_i,
  input  ltc_pkg::store_wr_t             wr_i,
  output ltc_pkg::store_rd_t             rd_o
);

  logic [ltc_pkg::TagW-1:0]  tag_mem  [ltc_pkg::MaxEntries];
  logic [ltc_pkg::SlotW-1:0] rank_mem [ltc_pkg::MaxEntries];

  logic [ltc_pkg::MaxEntries-1:0] valid_q;
  logic [ltc_pkg::MaxEntries-1:0] ranked_q;

  logic [ltc_pkg::TagW-1:0]  tag_rd_q;
  logic [ltc_pkg::SlotW-1:0] rank_rd_q;
  logic [ltc_pkg::SlotW-1:0] idx_rd_q;
  logic                      valid_rd_q;
  logic                      ranked_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ranked_q <= '0;
    end else if (wr_i.flush) begin
      valid_q  <= '0;
      ranked_q <= '0;
    end else begin
      if (wr_i.tag_we) begin
        valid_q[wr_i.tag_addr] <= 1'b1;
      end
      if (wr_i.rank_we) begin
        ranked_q[wr_i.rank_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we) begin
      tag_mem[wr_i.tag_addr] <= wr_i.tag_data;
    end
    if (wr_i.rank_we) begin
      rank_mem[wr_i.rank_addr] <= wr_i.rank_data;
    end
    tag_rd_q    <= tag_mem[rd_addr_i];
    rank_rd_q   <= rank_mem[rd_addr_i];
    idx_rd_q    <= rd_addr_i;
    valid_rd_q  <= valid_q[rd_addr_i];
    ranked_rd_q <= ranked_q[rd_addr_i];
  end

  // A rank never written since flush reads as its own slot index.
  assign rd_o.valid = valid_rd_q;
  assign rd_o.tag   = tag_rd_q;
  assign rd_o.rank  = ranked_rd_q ? rank_rd_q : idx_rd_q;

endmodule

### hw/rtl/lru_tag_cache_lookup.sv
// Top level: fully associative LRU tag lookup with a sequenced scan over the entry store.
//
//  channel   dir  handshake                      payload
//  request   in   request_valid_i/request_ready_o request_offset_i[31:0]
//  result    out  result_valid_o/result_ready_i  hit_o, slot_o[6:0], evicted_valid_o,
//                                                evicted_offset_o[31:0]
//  cfg       in   cfg_valid_i/cfg_ready_o        cfg_active_entries_i[7:0]
//
// Each request makes one pass over the single read port of the tag/rank store that
// matches and finds the LRU slot, then one read-modify-write pass that updates the
// ranks; each pass covers the slots in use.
// Reset and each cfg write clear valid and rank-written bits at once; no sweep.
// A new request is taken while the previous result waits in the output register.
module lru_tag_cache_lookup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           request_valid_i,
  output logic                           request_ready_o,
  input  logic [ltc_pkg::TagW-1:0]       request_offset_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic                           hit_o,
  output logic [ltc_pkg::SlotW-1:0]      slot_o,
  output logic                           evicted_valid_o,
  output logic [ltc_pkg::TagW-1:0]       evicted_offset_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ltc_pkg::CfgW-1:0]       cfg_active_entries_i
);

  ltc_pkg::ltc_state_e state_q, state_d;

  logic [ltc_pkg::CfgW-1:0]  active_q, active_d;
  logic [ltc_pkg::CntW-1:0]  n_eff;
  logic [ltc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      pv_q, pv_d;
  logic [ltc_pkg::SlotW-1:0] pidx_q, pidx_d;
  logic                      issue;

  logic [ltc_pkg::TagW-1:0]  req_tag_q, req_tag_d;
  logic                      found_q, found_d;
  logic [ltc_pkg::SlotW-1:0] hit_slot_q, hit_slot_d;
  logic [ltc_pkg::SlotW-1:0] hit_rank_q, hit_rank_d;
  logic                      lru_found_q, lru_found_d;
  logic [ltc_pkg::SlotW-1:0] lru_slot_q, lru_slot_d;
  logic [ltc_pkg::TagW-1:0]  lru_tag_q, lru_tag_d;
  logic                      lru_vld_q, lru_vld_d;
  logic [ltc_pkg::SlotW-1:0] sel_slot_q, sel_slot_d;
  logic [ltc_pkg::SlotW-1:0] sel_rank_q, sel_rank_d;

  logic                      res_hit_q, res_hit_d;
  logic                      res_ev_vld_q, res_ev_vld_d;
  logic [ltc_pkg::TagW-1:0]  res_ev_tag_q, res_ev_tag_d;

  logic                      out_vld_q, out_vld_d;
  logic                      out_hit_q, out_hit_d;
  logic [ltc_pkg::SlotW-1:0] out_slot_q, out_slot_d;
  logic                      out_ev_vld_q, out_ev_vld_d;
  logic [ltc_pkg::TagW-1:0]  out_ev_tag_q, out_ev_tag_d;

  logic [ltc_pkg::SlotW-1:0] rd_addr;
  ltc_pkg::store_wr_t        wr;
  ltc_pkg::store_rd_t        rd;

  ltc_entry_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_o      (rd)
  );

  // Slots in use: 0 acts as 1, anything above the store depth as the depth.
  always_comb begin
    if (active_q == '0) begin
      n_eff = ltc_pkg::CntW'(1);
    end else if (ltc_pkg::CntW'(active_q) > ltc_pkg::CntW'(ltc_pkg::MaxEntries)) begin
      n_eff = ltc_pkg::CntW'(ltc_pkg::MaxEntries);
    end else begin
      n_eff = ltc_pkg::CntW'(active_q);
    end
  end

  assign issue   = (cnt_q < n_eff);
  assign rd_addr = cnt_q[ltc_pkg::SlotW-1:0];

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    cnt_d        = cnt_q;
    pv_d         = 1'b0;
    pidx_d       = cnt_q[ltc_pkg::SlotW-1:0];
    req_tag_d    = req_tag_q;
    found_d      = found_q;
    hit_slot_d   = hit_slot_q;
    hit_rank_d   = hit_rank_q;
    lru_found_d  = lru_found_q;
    lru_slot_d   = lru_slot_q;
    lru_tag_d    = lru_tag_q;
    lru_vld_d    = lru_vld_q;
    sel_slot_d   = sel_slot_q;
    sel_rank_d   = sel_rank_q;
    res_hit_d    = res_hit_q;
    res_ev_vld_d = res_ev_vld_q;
    res_ev_tag_d = res_ev_tag_q;
    out_vld_d    = out_vld_q;
    out_hit_d    = out_hit_q;
    out_slot_d   = out_slot_q;
    out_ev_vld_d = out_ev_vld_q;
    out_ev_tag_d = out_ev_tag_q;
    wr           = '0;

    if (out_vld_q && result_ready_i) begin
      out_vld_d = 1'b0;
    end

    if (cfg_valid_i) begin
      active_d = cfg_active_entries_i;
      wr.flush = 1'b1;
    end

    unique case (state_q)
      ltc_pkg::StIdle: begin
        if (request_valid_i) begin
          req_tag_d   = request_offset_i;
          cnt_d       = '0;
          found_d     = 1'b0;
          lru_found_d = 1'b0;
          state_d     = ltc_pkg::StScan;
        end
      end

      ltc_pkg::StScan: begin
        pv_d = issue;
        if (issue) begin
          cnt_d = cnt_q + ltc_pkg::CntW'(1);
        end
        if (pv_q) begin
          // lowest matching slot wins
          if (rd.valid && (rd.tag == req_tag_q) && !found_q) begin
            found_d    = 1'b1;
            hit_slot_d = pidx_q;
            hit_rank_d = rd.rank;
          end
          if ((rd.rank == '0) && !lru_found_q) begin
            lru_found_d = 1'b1;
            lru_slot_d  = pidx_q;
            lru_tag_d   = rd.tag;
            lru_vld_d   = rd.valid;
          end
        end
        if (!issue && !pv_q) begin
          cnt_d = '0;
          if (found_q) begin
            sel_slot_d   = hit_slot_q;
            sel_rank_d   = hit_rank_q;
            res_hit_d    = 1'b1;
            res_ev_vld_d = 1'b0;
            res_ev_tag_d = '0;
          end else begin
            sel_slot_d   = lru_slot_q;
            sel_rank_d   = '0;
            res_hit_d    = 1'b0;
            res_ev_vld_d = lru_vld_q;
            res_ev_tag_d = lru_vld_q ? lru_tag_q : '0;
            wr.tag_we    = 1'b1;
            wr.tag_addr  = lru_slot_q;
            wr.tag_data  = req_tag_q;
          end
          state_d = ltc_pkg::StPromote;
        end
      end

      ltc_pkg::StPromote: begin
        pv_d = issue;
        if (issue) begin
          cnt_d = cnt_q + ltc_pkg::CntW'(1);
        end
        // read slot i+1 while writing back slot i
        if (pv_q) begin
          wr.rank_we   = 1'b1;
          wr.rank_addr = pidx_q;
          if (pidx_q == sel_slot_q) begin
            wr.rank_data = ltc_pkg::SlotW'(n_eff - ltc_pkg::CntW'(1));
          end else if (rd.rank > sel_rank_q) begin
            wr.rank_data = rd.rank - ltc_pkg::SlotW'(1);
          end else begin
            wr.rank_data = rd.rank;
          end
        end
        if (!issue && !pv_q) begin
          cnt_d   = '0;
          state_d = ltc_pkg::StDone;
        end
      end

      ltc_pkg::StDone: begin
        if (!out_vld_q || result_ready_i) begin
          out_vld_d    = 1'b1;
          out_hit_d    = res_hit_q;
          out_slot_d   = sel_slot_q;
          out_ev_vld_d = res_ev_vld_q;
          out_ev_tag_d = res_ev_tag_q;
          state_d      = ltc_pkg::StIdle;
        end
      end

      default: begin
        state_d = ltc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ltc_pkg::StIdle;
      active_q  <= ltc_pkg::ActiveReset;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    req_tag_q    <= req_tag_d;
    found_q      <= found_d;
    hit_slot_q   <= hit_slot_d;
    hit_rank_q   <= hit_rank_d;
    lru_found_q  <= lru_found_d;
    lru_slot_q   <= lru_slot_d;
    lru_tag_q    <= lru_tag_d;
    lru_vld_q    <= lru_vld_d;
    sel_slot_q   <= sel_slot_d;
    sel_rank_q   <= sel_rank_d;
    res_hit_q    <= res_hit_d;
    res_ev_vld_q <= res_ev_vld_d;
    res_ev_tag_q <= res_ev_tag_d;
    out_hit_q    <= out_hit_d;
    out_slot_q   <= out_slot_d;
    out_ev_vld_q <= out_ev_vld_d;
    out_ev_tag_q <= out_ev_tag_d;
  end

  assign request_ready_o  = (state_q == ltc_pkg::StIdle);
  assign cfg_ready_o      = 1'b1;
  assign result_valid_o   = out_vld_q;
  assign hit_o            = out_hit_q;
  assign slot_o           = out_slot_q;
  assign evicted_valid_o  = out_ev_vld_q;
  assign evicted_offset_o = out_ev_tag_q;

endmodule

### hw/rtl/ltc_checker.sv
// Port-level checker for the tag cache lookup block, bound to the top level.
`include "lru_tag_cache_lookup_assert.svh"

module ltc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           request_valid_i,
  input logic                           request_ready_o,
  input logic                           result_valid_o,
  input logic                           result_ready_i,
  input logic                           hit_o,
  input logic [ltc_pkg::SlotW-1:0]      slot_o,
  input logic                           evicted_valid_o,
  input logic [ltc_pkg::TagW-1:0]       evicted_offset_o
);

  // a stalled result stays valid with its slot and evicted offset held
  `LTC_ASSERT_NEXT(a_result_hold, result_valid_o && !result_ready_i,
                   result_valid_o && $stable(slot_o) && $stable(evicted_offset_o))

  // a hit never reports an eviction
  `LTC_ASSERT(a_hit_no_evict,
              result_valid_o && hit_o |-> !evicted_valid_o && evicted_offset_o == '0)

  // no displaced entry means a zero offset
  `LTC_ASSERT(a_evict_zero, result_valid_o && !evicted_valid_o |-> evicted_offset_o == '0)

  // the block is busy, and raises no new result, right after taking a request
  `LTC_ASSERT_NEXT(a_busy_after_req, request_valid_i && request_ready_o,
                   !request_ready_o && !$rose(result_valid_o))

endmodule

bind lru_tag_cache_lookup ltc_checker u_ltc_checker (.*);
